// ----- rtl/dual_wavetable_oscillator_lfo_macros.svh -----
// Assertion macros for the checker file of the oscillator block.
`ifndef DUAL_WAVETABLE_OSCILLATOR_LFO_MACROS_SVH
`define DUAL_WAVETABLE_OSCILLATOR_LFO_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define DWO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define DWO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dwo_pkg.sv -----
// Shared types, constants and the sine table builder for the oscillator block.
package dwo_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int PHASE_FRAC_DEF = 16;

    localparam int INC_W      = 26;
    localparam int LEVEL_W    = 16;
    localparam int WAVE_W     = 16;
    localparam int SAMPLE_W   = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = INC_W;

    localparam int MIX_SHIFT  = 15;
    localparam int AM_SHIFT   = 30;
    localparam int DEV_SHIFT  = 15;
    localparam int SAMPLE_MAX = 65536;
    localparam int WAVE_PEAK  = 32767;
    localparam int WAVE_HALF  = 32768;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OSC1_INC     = 3'd0,
        CFG_OSC2_INC     = 3'd1,
        CFG_FM_DEPTH_INC = 3'd2,
        CFG_AM_INC       = 3'd3,
        CFG_FM_INC       = 3'd4,
        CFG_OSC1_WAVE    = 3'd5,
        CFG_OSC2_WAVE    = 3'd6
    } t_cfg_idx;

    // Waveform select codes
    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave;

    // One input word
    typedef struct packed {
        logic [LEVEL_W-1:0] osc1_level;
        logic [LEVEL_W-1:0] osc2_level;
        logic [LEVEL_W-1:0] am_depth;
    } t_item;

    // Configuration register file
    typedef struct packed {
        logic [INC_W-1:0] osc1_inc;
        logic [INC_W-1:0] osc2_inc;
        logic [INC_W-1:0] fm_depth_inc;
        logic [INC_W-1:0] am_inc;
        logic [INC_W-1:0] fm_inc;
        t_wave            osc1_wave;
        t_wave            osc2_wave;
    } t_cfg;

    // One sine table entry, Q1.15, built from a Q2.30 Taylor series.
    // The table holds 2**tbits entries.
    function automatic logic signed [WAVE_W-1:0] sine_entry(input int unsigned idx,
                                                           input int unsigned tbits);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        n  = 64'd1 << tbits;
        m  = 64'(idx) << 2;
        q  = m >> tbits;
        r  = m & (n - 64'd1);
        if (q[0]) begin
            r = n - r;
        end
        x  = (HALF_PI_Q30 * r) >> tbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        if (q >= 64'd2) begin
            v = 64'd0 - v;
        end
        return WAVE_W'(v);
    endfunction

endpackage

// ----- rtl/dwo_front.sv -----
// Input queue: takes words from the push side and holds them for the sequencer.
module dwo_front import dwo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    // Track fill level
    always_comb begin
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Store incoming word
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ----- rtl/dwo_sine_rom.sv -----
// Sine table ROM with a registered read port.
module dwo_sine_rom import dwo_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic [$clog2(TABLE_SIZE)-1:0]     i_addr,
    output logic signed [WAVE_W-1:0]          o_data
);

    localparam int TABLE_BITS = $clog2(TABLE_SIZE);

    typedef logic signed [WAVE_W-1:0] t_rom [TABLE_SIZE];

    function automatic t_rom build_rom();
        t_rom        rom;
        int unsigned i;
        for (i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = sine_entry(i, TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom C_SINE = build_rom();

    logic signed [WAVE_W-1:0] r_data;

    // Read one entry per cycle
    always_ff @(posedge i_clk) begin
        r_data <= C_SINE[i_addr];
    end

    assign o_data = r_data;

endmodule

// ----- rtl/dwo_back.sv -----
// Sample sequencer: table reads, mix, amplitude modulation, phase update, result register.
module dwo_back import dwo_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int PHASE_FRAC = PHASE_FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_item_valid,
    input  t_item                      i_item,
    output logic                       o_item_take,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int PHASE_W    = TABLE_BITS + PHASE_FRAC;
    localparam int DEV_W      = INC_W + 1;
    localparam int ACC_W      = (PHASE_W > DEV_W) ? PHASE_W : DEV_W;
    localparam int VAL_W      = WAVE_W + 2;
    localparam int MIX_P_W    = WAVE_W + LEVEL_W + 1;
    localparam int MIX_S_W    = MIX_P_W + 1;
    localparam int MIX_W      = MIX_S_W - MIX_SHIFT;
    localparam int FPROD_W    = 2 * LEVEL_W;
    localparam int FACT_W     = FPROD_W + 1;
    localparam int AM_P_W     = MIX_W + FACT_W;
    localparam int Y_W        = AM_P_W - AM_SHIFT;
    localparam int DEVP_W     = WAVE_W + INC_W;
    localparam int SAW_SH     = WAVE_W - TABLE_BITS;
    localparam int TRI_UP_SH  = WAVE_W + 1 - TABLE_BITS;
    localparam int TRI_DN_SH  = WAVE_W - 1 - TABLE_BITS;

    localparam logic signed [VAL_W-1:0]   VAL_HALF = VAL_W'(WAVE_HALF);
    localparam logic signed [VAL_W-1:0]   VAL_PEAK = VAL_W'(WAVE_PEAK);
    localparam logic signed [MIX_S_W-1:0] MIX_RND  = MIX_S_W'(2 ** (MIX_SHIFT - 1));
    localparam logic signed [FACT_W-1:0]  AM_ONE   = FACT_W'(2 ** AM_SHIFT);
    localparam logic signed [AM_P_W-1:0]  AM_RND   = AM_P_W'(2 ** (AM_SHIFT - 1));
    localparam logic signed [DEVP_W-1:0]  DEV_RND  = DEVP_W'(2 ** (DEV_SHIFT - 1));
    localparam logic signed [Y_W-1:0]     Y_HI     = Y_W'(SAMPLE_MAX);
    localparam logic signed [Y_W-1:0]     Y_LO     = Y_W'(-SAMPLE_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OSC1,
        ST_RD_OSC2,
        ST_RD_AM,
        ST_RD_FM,
        ST_MIX,
        ST_MOD,
        ST_DONE
    } t_state;

    t_state                      r_state;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic [PHASE_W-1:0]          r_ph1;
    logic [PHASE_W-1:0]          r_ph2;
    logic [PHASE_W-1:0]          r_ph_am;
    logic [PHASE_W-1:0]          r_ph_fm;

    t_item                       r_item;
    logic signed [WAVE_W-1:0]    r_v1;
    logic signed [WAVE_W-1:0]    r_v2;
    logic signed [WAVE_W-1:0]    r_lfo;
    logic signed [WAVE_W-1:0]    r_fm;
    logic signed [MIX_P_W-1:0]   r_p1;
    logic signed [MIX_P_W-1:0]   r_p2;
    logic signed [MIX_W-1:0]     r_m;
    logic [FPROD_W-1:0]          r_fprod;
    logic signed [AM_P_W-1:0]    r_prod;
    logic signed [DEVP_W-1:0]    r_devp;

    logic [TABLE_BITS-1:0]       idx1;
    logic [TABLE_BITS-1:0]       idx2;
    logic [TABLE_BITS-1:0]       idx_am;
    logic [TABLE_BITS-1:0]       idx_fm;
    logic [TABLE_BITS-1:0]       rom_addr;
    logic signed [WAVE_W-1:0]    rom_data;
    logic signed [WAVE_W-1:0]    wave1;
    logic signed [WAVE_W-1:0]    wave2;
    logic [WAVE_W:0]             span_full;
    logic [LEVEL_W-1:0]          lfo_span;
    logic signed [MIX_S_W-1:0]   mix_sum;
    logic signed [FACT_W-1:0]    factor;
    logic signed [AM_P_W-1:0]    am_sum;
    logic signed [Y_W-1:0]       y;
    logic signed [Y_W-1:0]       y_sat;
    logic signed [DEVP_W-1:0]    dev_sum;
    logic signed [DEV_W-1:0]     dev;
    logic signed [ACC_W-1:0]     dev_ext;
    logic [PHASE_W-1:0]          n_ph1;
    logic [PHASE_W-1:0]          n_ph2;
    logic [PHASE_W-1:0]          n_ph_am;
    logic [PHASE_W-1:0]          n_ph_fm;
    logic                        slot_free;

    // Waveform value at a table index; sine comes from the ROM
    function automatic logic signed [WAVE_W-1:0] wave_value(input t_wave sel,
            input logic [TABLE_BITS-1:0] idx, input logic signed [WAVE_W-1:0] sine);
        logic [VAL_W-1:0]        up;
        logic signed [VAL_W-1:0] val;
        up  = '0;
        val = '0;
        unique case (sel)
            WAVE_SINE: begin
                val = VAL_W'(sine);
            end
            WAVE_SAW: begin
                up  = VAL_W'(idx) << SAW_SH;
                val = $signed(up) - VAL_HALF;
            end
            WAVE_TRI: begin
                if (!idx[TABLE_BITS-1]) begin
                    up  = VAL_W'(idx) << TRI_UP_SH;
                    val = $signed(up) - VAL_HALF;
                end else begin
                    up  = ((VAL_W'(idx) << 2) - VAL_W'(2 * TABLE_SIZE)) << TRI_DN_SH;
                    val = VAL_HALF - $signed(up);
                end
                if (val > VAL_PEAK) begin
                    val = VAL_PEAK;
                end
            end
            WAVE_SQUARE: begin
                val = idx[TABLE_BITS-1] ? VAL_PEAK : -VAL_PEAK;
            end
        endcase
        return WAVE_W'(val);
    endfunction

    dwo_sine_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    assign idx1   = r_ph1[PHASE_W-1 -: TABLE_BITS];
    assign idx2   = r_ph2[PHASE_W-1 -: TABLE_BITS];
    assign idx_am = r_ph_am[PHASE_W-1 -: TABLE_BITS];
    assign idx_fm = r_ph_fm[PHASE_W-1 -: TABLE_BITS];

    // Pick the table address for this step
    always_comb begin
        unique case (r_state)
            ST_RD_OSC2: rom_addr = idx2;
            ST_RD_AM:   rom_addr = idx_am;
            ST_RD_FM:   rom_addr = idx_fm;
            default:    rom_addr = idx1;
        endcase
    end

    assign slot_free   = !r_out_valid || i_pop;
    assign o_item_take = i_item_valid &&
                         ((r_state == ST_IDLE) || ((r_state == ST_DONE) && slot_free));
    assign o_empty     = !r_out_valid;
    assign o_sample    = r_sample;

    // Waveform shaping and the arithmetic between registers
    always_comb begin
        wave1     = wave_value(i_cfg.osc1_wave, idx1, rom_data);
        wave2     = wave_value(i_cfg.osc2_wave, idx2, rom_data);
        span_full = (WAVE_W+1)'(WAVE_HALF) - (WAVE_W+1)'(r_lfo);
        lfo_span  = span_full[LEVEL_W-1:0];
        mix_sum   = MIX_S_W'(r_p1) + MIX_S_W'(r_p2) + MIX_RND;
        factor    = AM_ONE - $signed({1'b0, r_fprod});
        am_sum    = r_prod + AM_RND;
        y         = Y_W'(am_sum >>> AM_SHIFT);
        if (y > Y_HI) begin
            y_sat = Y_HI;
        end else if (y < Y_LO) begin
            y_sat = Y_LO;
        end else begin
            y_sat = y;
        end
        dev_sum   = r_devp + DEV_RND;
        dev       = DEV_W'(dev_sum >>> DEV_SHIFT);
        dev_ext   = ACC_W'(dev);
        n_ph1     = PHASE_W'(ACC_W'(r_ph1) + ACC_W'(i_cfg.osc1_inc) + dev_ext);
        n_ph2     = PHASE_W'(ACC_W'(r_ph2) + ACC_W'(i_cfg.osc2_inc) + dev_ext);
        n_ph_am   = PHASE_W'(ACC_W'(r_ph_am) + ACC_W'(i_cfg.am_inc));
        n_ph_fm   = PHASE_W'(ACC_W'(r_ph_fm) + ACC_W'(i_cfg.fm_inc));
    end

    // Sequence state, phases and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ph1       <= '0;
            r_ph2       <= '0;
            r_ph_am     <= '0;
            r_ph_fm     <= '0;
        end else begin
            // Fill the result slot when a sample completes, clear it on pop
            if ((r_state == ST_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_state <= ST_RD_OSC1;
                    end
                end
                ST_RD_OSC1: r_state <= ST_RD_OSC2;
                ST_RD_OSC2: r_state <= ST_RD_AM;
                ST_RD_AM:   r_state <= ST_RD_FM;
                ST_RD_FM:   r_state <= ST_MIX;
                ST_MIX:     r_state <= ST_MOD;
                ST_MOD:     r_state <= ST_DONE;
                ST_DONE: begin
                    if (slot_free) begin
                        r_sample    <= SAMPLE_W'(y_sat);
                        r_ph1       <= n_ph1;
                        r_ph2       <= n_ph2;
                        r_ph_am     <= n_ph_am;
                        r_ph_fm     <= n_ph_fm;
                        r_state     <= i_item_valid ? ST_RD_OSC1 : ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Datapath registers; one product per step, two in the modulation step
    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_item <= i_item;
        end
        case (r_state)
            ST_RD_OSC2: begin
                r_v1 <= wave1;
            end
            ST_RD_AM: begin
                r_v2 <= wave2;
                r_p1 <= MIX_P_W'(r_v1) * MIX_P_W'($signed({1'b0, r_item.osc1_level}));
            end
            ST_RD_FM: begin
                r_lfo <= rom_data;
                r_p2  <= MIX_P_W'(r_v2) * MIX_P_W'($signed({1'b0, r_item.osc2_level}));
            end
            ST_MIX: begin
                r_fm    <= rom_data;
                r_m     <= MIX_W'(mix_sum >>> MIX_SHIFT);
                r_fprod <= FPROD_W'(r_item.am_depth) * FPROD_W'(lfo_span);
            end
            ST_MOD: begin
                r_prod <= AM_P_W'(r_m) * AM_P_W'(factor);
                r_devp <= DEVP_W'(r_fm) * DEVP_W'($signed({1'b0, i_cfg.fm_depth_inc}));
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/dual_wavetable_oscillator_lfo.sv -----
// Top level of the dual wavetable oscillator with amplitude and frequency LFOs.
//
// Each word pushed in (two oscillator levels and an AM depth) yields one sample word.
// A sample is formed step by step, the sequencer starting from idle or straight after the
// last sample when words arrive back to back: four reads of the single-port sine
// ROM (oscillator one, oscillator two, AM LFO, FM LFO), then the mix, the modulation
// product and the phase update. A two-word input queue and a one-word result register
// let both sides stall on their own. The sine table is a constant ROM, so there is no
// clearing pass after reset. Configuration writes are taken every cycle (ready is
// always high) and must only be issued while no sample is in progress.
module dual_wavetable_oscillator_lfo import dwo_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int PHASE_FRAC = PHASE_FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [LEVEL_W-1:0]         i_osc1_level,
    input  logic [LEVEL_W-1:0]         i_osc2_level,
    input  logic [LEVEL_W-1:0]         i_am_depth,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg  r_cfg;
    t_item in_item;
    t_item q_item;
    logic  q_valid;
    logic  q_take;

    assign o_cfg_ready = 1'b1;
    assign in_item     = '{osc1_level: i_osc1_level,
                           osc2_level: i_osc2_level,
                           am_depth:   i_am_depth};

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OSC1_INC:     r_cfg.osc1_inc     <= i_cfg_data;
                CFG_OSC2_INC:     r_cfg.osc2_inc     <= i_cfg_data;
                CFG_FM_DEPTH_INC: r_cfg.fm_depth_inc <= i_cfg_data;
                CFG_AM_INC:       r_cfg.am_inc       <= i_cfg_data;
                CFG_FM_INC:       r_cfg.fm_inc       <= i_cfg_data;
                CFG_OSC1_WAVE:    r_cfg.osc1_wave    <= t_wave'(i_cfg_data[1:0]);
                CFG_OSC2_WAVE:    r_cfg.osc2_wave    <= t_wave'(i_cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    dwo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (in_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    dwo_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .PHASE_FRAC (PHASE_FRAC)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_take  (q_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_sample     (o_sample)
    );

endmodule

// ----- rtl/dwo_checker.sv -----
// Port-level checker for the oscillator block, bound to the top level.
`include "dual_wavetable_oscillator_lfo_macros.svh"

module dwo_checker import dwo_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int MAX_IN_FLIGHT = 4;
    localparam int PEND_W        = 4;

    localparam logic signed [SAMPLE_W-1:0] S_HI = SAMPLE_W'(SAMPLE_MAX);
    localparam logic signed [SAMPLE_W-1:0] S_LO = SAMPLE_W'(-SAMPLE_MAX);

    logic [PEND_W-1:0] r_pending;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // Count words accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + PEND_W'(in_acc) - PEND_W'(out_acc);
        end
    end

    `DWO_ASSERT_NOW(a_sample_range, i_clk, i_rst_n, !empty, (o_sample <= S_HI) && (o_sample >= S_LO), "sample outside saturation range")
    `DWO_ASSERT_NOW(a_no_phantom, i_clk, i_rst_n, r_pending == '0, empty, "result without a pending input word")
    `DWO_ASSERT_NOW(a_bounded, i_clk, i_rst_n, 1'b1, r_pending <= PEND_W'(MAX_IN_FLIGHT), "more words in flight than buffers")
    `DWO_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_sample), "stalled result changed")

endmodule

bind dual_wavetable_oscillator_lfo dwo_checker u_dwo_checker (.*);

// ----- tb/dual_wavetable_oscillator_lfo_test.sv -----
// Self-checking testbench for the dual wavetable oscillator with AM and FM LFOs.
`timescale 1ns / 100ps

module dual_wavetable_oscillator_lfo_test;
    import dwo_pkg::*;

    localparam int     TAB_N           = TABLE_SIZE_DEF;
    localparam int     FRAC            = PHASE_FRAC_DEF;
    localparam longint PH_MOD          = longint'(TAB_N) << FRAC;
    localparam int     CYCLES_PER_WORD = 8;
    localparam int     QUIET_LIMIT     = 2000;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     RAND_PHASES     = 8;
    localparam int     WORDS_PER_PHASE = 70;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE = 3'd7;
    localparam logic [CFG_DATA_W-1:0] INC_MAX   = '1;
    localparam logic [CFG_DATA_W-1:0] INC_HIGH  = 26'h2000000;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // One line of the directed plan: a register write or a sample word
    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        t_item                      word;
        logic                       known;
        logic signed [SAMPLE_W-1:0] want;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [LEVEL_W-1:0]         i_osc1_level = '0;
    logic [LEVEL_W-1:0]         i_osc2_level = '0;
    logic [LEVEL_W-1:0]         i_am_depth = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    // Oscillator model state
    logic signed [WAVE_W-1:0]   sine_tab [TAB_N];
    t_cfg                       osc_cfg;
    longint                     ph_osc1, ph_osc2, ph_am, ph_fm;

    logic signed [SAMPLE_W-1:0] due_samples [$];
    t_row                       plan [$];
    int                         mismatches = 0;
    int                         send_gap_pct = 0;
    int                         stall_pct = 0;
    bit                         rx_hold = 1'b0;

    dual_wavetable_oscillator_lfo dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_osc1_level (i_osc1_level),
        .i_osc2_level (i_osc2_level),
        .i_am_depth   (i_am_depth),
        .empty        (empty),
        .pop          (pop),
        .o_sample     (o_sample),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Quarter-wave folded Taylor sine, Q1.15
    function automatic logic signed [WAVE_W-1:0] sine_point(int unsigned i);
        longint unsigned quad, rem, ang, a2, tay, s, v;
        longint unsigned divs [4];
        logic signed [WAVE_W-1:0] mag;
        divs = '{64'd72, 64'd42, 64'd20, 64'd6};
        quad = (64'd4 * i) / TAB_N;
        rem  = (64'd4 * i) % TAB_N;
        if (quad[0]) begin
            rem = TAB_N - rem;
        end
        ang = (HALF_PI_Q30 * rem) / TAB_N;
        a2  = (ang * ang) >> 30;
        tay = Q30_ONE - a2 / 64'd110;
        foreach (divs[k]) begin
            tay = Q30_ONE - ((a2 * tay) >> 30) / divs[k];
        end
        s = (ang * tay) >> 30;
        v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        mag = v[WAVE_W-1:0];
        return (quad >= 2) ? -mag : mag;
    endfunction

    // Waveform value at a table index
    function automatic longint wave_at(t_wave sel, longint idx);
        longint v;
        case (sel)
            WAVE_SINE: return longint'(sine_tab[idx]);
            WAVE_SAW:  return (longint'(65536) * idx) / TAB_N - WAVE_HALF;
            WAVE_TRI: begin
                if (2 * idx < TAB_N) begin
                    v = (longint'(131072) * idx) / TAB_N - WAVE_HALF;
                end else begin
                    v = WAVE_HALF - (longint'(32768) * (4 * idx - 2 * TAB_N)) / TAB_N;
                end
                return (v > WAVE_PEAK) ? WAVE_PEAK : v;
            end
            default:   return (2 * idx < TAB_N) ? -WAVE_PEAK : WAVE_PEAK;
        endcase
    endfunction

    // Round half up, then drop n fraction bits
    function automatic longint round_q(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint wrap_ph(longint t);
        t = t % PH_MOD;
        if (t < 0) begin
            t += PH_MOD;
        end
        return t;
    endfunction

    // Form one sample from the current phases, then advance all four phases
    function automatic logic signed [SAMPLE_W-1:0] synth_sample(t_item w);
        longint l1, l2, d, v1, v2, lfo, fmv, mix, gain, y, dev, depth_inc;
        l1  = w.osc1_level;
        l2  = w.osc2_level;
        d   = w.am_depth;
        v1  = wave_at(osc_cfg.osc1_wave, ph_osc1 >> FRAC);
        v2  = wave_at(osc_cfg.osc2_wave, ph_osc2 >> FRAC);
        lfo = sine_tab[ph_am >> FRAC];
        fmv = sine_tab[ph_fm >> FRAC];
        mix  = round_q(v1 * l1 + v2 * l2, MIX_SHIFT);
        gain = (longint'(1) <<< AM_SHIFT) - d * (WAVE_HALF - lfo);
        y    = round_q(mix * gain, AM_SHIFT);
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
        end
        if (y < -SAMPLE_MAX) begin
            y = -SAMPLE_MAX;
        end
        depth_inc = osc_cfg.fm_depth_inc;
        dev = round_q(fmv * depth_inc, DEV_SHIFT);
        ph_osc1 = wrap_ph(ph_osc1 + longint'(osc_cfg.osc1_inc) + dev);
        ph_osc2 = wrap_ph(ph_osc2 + longint'(osc_cfg.osc2_inc) + dev);
        ph_am   = wrap_ph(ph_am + longint'(osc_cfg.am_inc));
        ph_fm   = wrap_ph(ph_fm + longint'(osc_cfg.fm_inc));
        return SAMPLE_W'(y);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OSC1_INC:     osc_cfg.osc1_inc = data;
            CFG_OSC2_INC:     osc_cfg.osc2_inc = data;
            CFG_FM_DEPTH_INC: osc_cfg.fm_depth_inc = data;
            CFG_AM_INC:       osc_cfg.am_inc = data;
            CFG_FM_INC:       osc_cfg.fm_inc = data;
            CFG_OSC1_WAVE:    osc_cfg.osc1_wave = t_wave'(data[1:0]);
            CFG_OSC2_WAVE:    osc_cfg.osc2_wave = t_wave'(data[1:0]);
            default: ;
        endcase
    endfunction

    function automatic void add_word(int l1, int l2, int d, logic known,
                                     logic signed [SAMPLE_W-1:0] want);
        t_row row;
        row = '0;
        row.kind = ROW_WORD;
        row.word.osc1_level = LEVEL_W'(l1);
        row.word.osc2_level = LEVEL_W'(l2);
        row.word.am_depth   = LEVEL_W'(d);
        row.known = known;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        plan.push_back(row);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'd32768;
            2:       return '1;
            3, 4:    return LEVEL_W'($urandom);
            default: return LEVEL_W'($urandom_range(32768));
        endcase
    endfunction

    // Phase one takes every step at its top, phase two every step at zero
    function automatic logic [CFG_DATA_W-1:0] pick_inc(int ph);
        if (ph == 1) begin
            return INC_MAX;
        end
        if (ph == 2) begin
            return '0;
        end
        case ($urandom_range(5))
            0:       return '0;
            1:       return INC_MAX;
            2:       return INC_HIGH;
            3:       return CFG_DATA_W'($urandom_range(32'd20 << 16));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Offer one word, with random idle cycles ahead of it; hold push high after accept
    task automatic send_word(t_item w, logic known, logic signed [SAMPLE_W-1:0] want);
        logic signed [SAMPLE_W-1:0] y;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_osc1_level <= w.osc1_level;
        i_osc2_level <= w.osc2_level;
        i_am_depth   <= w.am_depth;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        y = synth_sample(w);
        due_samples.push_back(known ? want : y);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every sample, then let the phase update settle
    task automatic drain_samples();
        @(negedge i_clk);
        push <= 1'b0;
        while (due_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (CYCLES_PER_WORD) @(posedge i_clk);
    endtask

    task automatic hold_results(int n);
        rx_hold = 1'b1;
        repeat (n) @(posedge i_clk);
        rx_hold = 1'b0;
    endtask

    // Result side: pop at random, check each word against the oldest expectation
    initial begin : result_side
        logic signed [SAMPLE_W-1:0] want;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(negedge i_clk);
            pop <= !rx_hold && ($urandom_range(99) >= stall_pct);
            @(posedge i_clk);
            if (pop && !empty) begin
                if (due_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 40) begin
                        $display("%0t: sample %0d with none expected", $time, o_sample);
                    end
                end else begin
                    want = due_samples.pop_front();
                    if (o_sample !== want) begin
                        mismatches++;
                        if (mismatches <= 40) begin
                            $display("%0t: sample expected %0d, got %0d",
                                     $time, want, o_sample);
                        end
                    end
                end
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("dual_wavetable_oscillator_lfo_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_item w;
        for (int i = 0; i < TAB_N; i++) begin
            sine_tab[i] = sine_point(i);
        end
        osc_cfg = '0;
        ph_osc1 = 0;
        ph_osc2 = 0;
        ph_am   = 0;
        ph_fm   = 0;

        // Reset state: every phase at zero, both oscillators on sine at index zero
        add_word(32768, 32768, 0, 1'b1, 18'sd0);
        add_word(65535, 65535, 65535, 1'b1, 18'sd0);
        // Square and saw at index zero, wave selects with surplus bits set
        add_cfg(CFG_OSC1_WAVE, {24'hFFFFFF, WAVE_SQUARE});
        add_cfg(CFG_OSC2_WAVE, {24'hAAAAAA, WAVE_SAW});
        add_cfg(CFG_SPARE, INC_MAX);
        add_word(65535, 65535, 0, 1'b1, -18'sd65536);
        add_word(65535, 65535, 32768, 1'b1, 18'sd0);
        add_word(65535, 65535, 65535, 1'b1, 18'sd65536);
        add_word(0, 0, 0, 1'b1, 18'sd0);
        add_word(32768, 0, 0, 1'b1, -18'sd32767);
        add_word(0, 32768, 0, 1'b1, -18'sd32768);
        add_word(0, 0, 65535, 1'b1, 18'sd0);
        // Moving phases with full FM depth, so the phase sum goes negative
        add_cfg(CFG_OSC1_WAVE, {24'h000000, WAVE_TRI});
        add_cfg(CFG_OSC2_WAVE, {24'h555555, WAVE_SINE});
        add_cfg(CFG_OSC1_INC, INC_MAX);
        add_cfg(CFG_OSC2_INC, (26'd37 << 16) | 26'h1234);
        add_cfg(CFG_FM_DEPTH_INC, INC_MAX);
        add_cfg(CFG_AM_INC, 26'd300 << 16);
        add_cfg(CFG_FM_INC, (26'd200 << 16) + 26'd77);
        add_word(32768, 32768, 16384, 1'b0, '0);
        add_word(65535, 0, 32768, 1'b0, '0);
        add_word(0, 65535, 0, 1'b0, '0);
        add_word(12345, 54321, 40000, 1'b0, '0);
        add_word(32768, 32768, 0, 1'b0, '0);
        add_word(1, 1, 1, 1'b0, '0);
        add_word(32768, 0, 65535, 1'b0, '0);
        add_word(0, 32768, 8192, 1'b0, '0);
        add_cfg(CFG_OSC1_WAVE, {24'h000000, WAVE_SAW});
        add_cfg(CFG_OSC2_WAVE, {24'h000000, WAVE_TRI});
        add_cfg(CFG_AM_INC, INC_HIGH);
        add_cfg(CFG_FM_INC, INC_MAX);
        add_word(30000, 30000, 20000, 1'b0, '0);
        add_word(65535, 65535, 0, 1'b0, '0);
        add_word(20000, 10000, 5000, 1'b0, '0);
        add_cfg(CFG_OSC1_WAVE, {24'h000000, WAVE_SINE});
        add_cfg(CFG_OSC2_WAVE, {24'h000000, WAVE_SQUARE});
        add_cfg(CFG_OSC1_INC, 26'd0);
        add_word(32768, 32768, 32768, 1'b0, '0);
        add_word(40000, 20000, 0, 1'b0, '0);
        add_word(16384, 65535, 49152, 1'b0, '0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed plan
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                if (r > 0 && plan[r-1].kind == ROW_WORD) begin
                    drain_samples();
                end
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                send_word(plan[r].word, plan[r].known, plan[r].want);
            end
        end

        // Random phases, each with fresh registers and its own idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_samples();
            write_reg(CFG_OSC1_INC, pick_inc(ph));
            write_reg(CFG_OSC2_INC, pick_inc(ph));
            write_reg(CFG_FM_DEPTH_INC, pick_inc(ph));
            write_reg(CFG_AM_INC, pick_inc(ph));
            write_reg(CFG_FM_INC, pick_inc(ph));
            write_reg(CFG_OSC1_WAVE, CFG_DATA_W'($urandom));
            write_reg(CFG_OSC2_WAVE, CFG_DATA_W'($urandom));
            if (ph % 3 == 0) begin
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            end
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 48; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 48; end
                default: begin send_gap_pct = 19; stall_pct = 19; end
            endcase
            // Back up the result side while words keep coming
            if (ph == 0) begin
                fork
                    hold_results(HOLD_CYCLES);
                join_none
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (ph == 5 && k == WORDS_PER_PHASE / 2) begin
                    drain_samples();
                end
                w.osc1_level = pick_level();
                w.osc2_level = pick_level();
                w.am_depth   = pick_level();
                send_word(w, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        push <= 1'b0;
        send_gap_pct = 0;
        stall_pct = 0;
        while (due_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4 * CYCLES_PER_WORD) @(posedge i_clk);
        if (mismatches == 0 && due_samples.size() == 0) begin
            $display("dual_wavetable_oscillator_lfo_test: done, clean");
        end else begin
            $display("dual_wavetable_oscillator_lfo_test: done, errors");
        end
        $finish;
    end

endmodule
